@@ rtl/core/wp_pkg.sv @@
// shared types, constants and the arctangent table for the waypoint velocity block
package wp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int EW            = 25;
  localparam int CW            = 36;
  localparam int ZW            = 34;
  localparam int WZW           = 26;
  localparam int Q_DEPTH       = 4;
  localparam int QAW           = $clog2(Q_DEPTH);
  localparam logic [16:0] INV_K = 17'd39797;

  typedef enum logic [2:0] {
    REG_KP_POS  = 3'd0,
    REG_KP_YAW  = 3'd1,
    REG_POS_TOL = 3'd2,
    REG_YAW_TOL = 3'd3,
    REG_MAX_VX  = 3'd4,
    REG_MAX_VY  = 3'd5,
    REG_MAX_WZ  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] kp_pos;
    logic [15:0] kp_yaw;
    logic [19:0] pos_tol;
    logic [15:0] yaw_tol;
    logic [22:0] max_vx;
    logic [22:0] max_vy;
    logic [22:0] max_wz;
  } wp_cfg_t;

  typedef struct packed {
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [ZW-1:0]  z;
    logic                  pos_zero;
    logic signed [WZW-1:0] wz;
  } wp_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wp_qstat_t;

  function automatic logic signed [ZW-1:0] atan_ang(input int unsigned idx);
    case (idx)
      0:  return 34'h20000000;
      1:  return 34'h12E4051E;
      2:  return 34'h09FB385B;
      3:  return 34'h051111D4;
      4:  return 34'h028B0D43;
      5:  return 34'h0145D7E1;
      6:  return 34'h00A2F61E;
      7:  return 34'h00517C55;
      8:  return 34'h0028BE53;
      9:  return 34'h00145F2F;
      10: return 34'h000A2F98;
      11: return 34'h000517CC;
      12: return 34'h00028BE6;
      13: return 34'h000145F3;
      14: return 34'h0000A2FA;
      15: return 34'h0000517D;
      16: return 34'h000028BF;
      17: return 34'h0000145F;
      18: return 34'h00000A30;
      19: return 34'h00000518;
      20: return 34'h0000028C;
      21: return 34'h00000146;
      22: return 34'h000000A3;
      23: return 34'h00000051;
      default: return '0;
    endcase
  endfunction

endpackage

@@ rtl/core/wp_if.sv @@
// input item, output command and configuration write channel interfaces
interface wp_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] robot_x;
  logic signed [23:0] robot_y;
  logic [15:0]        robot_yaw;
  logic signed [23:0] target_x;
  logic signed [23:0] target_y;
  logic [15:0]        target_yaw;
  logic               use_yaw;

  modport source (output valid, robot_x, robot_y, robot_yaw, target_x, target_y,
                  target_yaw, use_yaw, input ready);
  modport sink (input valid, robot_x, robot_y, robot_yaw, target_x, target_y,
                target_yaw, use_yaw, output ready);
endinterface

interface wp_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] vel_x;
  logic signed [23:0] vel_y;
  logic signed [23:0] yaw_rate;

  modport source (output valid, vel_x, vel_y, yaw_rate, input ready);
  modport sink (input valid, vel_x, vel_y, yaw_rate, output ready);
endinterface

interface wp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [22:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/waypoint_velocity_command.sv @@
// top level: configuration registers, front end, item queue and back end
// Proportional waypoint controller in the body frame. Takes one pose item per clock while
// the output side is not stalled and returns one velocity command per item, in order. Each
// item passes two front-end stages, the item queue, one CORDIC stage per iteration, then
// gain compensation, position gain and saturation. Sustained rate is one item per cycle
// under that condition, set by the fully pipelined CORDIC and the one-multiply-per-stage
// scaling. A four-item queue lets the front keep accepting while the result side is
// stalled, until the queue is full. Configuration writes are always ready; each stage reads
// the registers directly, so a write also affects items already in flight.
module waypoint_velocity_command import wp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  wp_in_if.sink    in_if,
  wp_out_if.source out_if,
  wp_cfg_if.sink   cfg_if
);

  wp_cfg_t   cfg_r, cfg_nxt;
  wp_qstat_t qstat;
  wp_job_t   push_job, pop_job;
  logic      push, pop;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_reg_t'(cfg_if.index))
        REG_KP_POS:  cfg_nxt.kp_pos  = cfg_if.data[15:0];
        REG_KP_YAW:  cfg_nxt.kp_yaw  = cfg_if.data[15:0];
        REG_POS_TOL: cfg_nxt.pos_tol = cfg_if.data[19:0];
        REG_YAW_TOL: cfg_nxt.yaw_tol = cfg_if.data[15:0];
        REG_MAX_VX:  cfg_nxt.max_vx  = cfg_if.data;
        REG_MAX_VY:  cfg_nxt.max_vy  = cfg_if.data;
        REG_MAX_WZ:  cfg_nxt.max_wz  = cfg_if.data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_pos  <= 16'd256;
      cfg_r.kp_yaw  <= 16'd512;
      cfg_r.pos_tol <= 20'd20;
      cfg_r.yaw_tol <= 16'd182;
      cfg_r.max_vx  <= 23'd1024;
      cfg_r.max_vy  <= 23'd1024;
      cfg_r.max_wz  <= 23'd16384;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  wp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .in_if (in_if),
    .qstat (qstat),
    .push  (push),
    .job   (push_job)
  );

  wp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .qstat     (qstat)
  );

  wp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .job    (pop_job),
    .qstat  (qstat),
    .pop    (pop),
    .out_if (out_if)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("item pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("item popped from an empty queue");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> qstat.full)
    else $error("input stalled while the queue has room");

endmodule

@@ rtl/core/wp_front.sv @@
// front end: error forming, quadrant fold, deadband squares and yaw term
module wp_front import wp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  wp_cfg_t   cfg,
  wp_in_if.sink     in_if,
  input  wp_qstat_t qstat,
  output logic      push,
  output wp_job_t   job
);

  logic en;

  logic                  f1_v_r;
  logic signed [EW-1:0]  f1_ex_r;
  logic signed [EW-1:0]  f1_ey_r;
  logic [31:0]           f1_zu_r;
  logic [15:0]           f1_yerr_r;
  logic                  f1_use_r;
  logic                  f1_inr_r;

  logic                  f2_v_r;
  logic signed [CW-1:0]  f2_x_r;
  logic signed [CW-1:0]  f2_y_r;
  logic signed [ZW-1:0]  f2_z_r;
  logic [39:0]           f2_sqx_r;
  logic [39:0]           f2_sqy_r;
  logic [39:0]           f2_tolsq_r;
  logic signed [33:0]    f2_yprod_r;
  logic                  f2_use_r;
  logic                  f2_inr_r;

  logic signed [EW-1:0]    ex, ey;
  logic                    neg;
  logic signed [CW-1:0]    xs, ys;
  logic [31:0]             zf;
  logic signed [2*EW-1:0]  sqx, sqy;
  logic signed [33:0]      yprod;
  logic [40:0]             sq_sum;
  logic signed [WZW-1:0]   wzr;
  logic [WZW-1:0]          wabs;

  assign en          = !f2_v_r || !qstat.full;
  assign in_if.ready = en;
  assign push        = f2_v_r && !qstat.full;

  assign ex = {in_if.target_x[23], in_if.target_x} - {in_if.robot_x[23], in_if.robot_x};
  assign ey = {in_if.target_y[23], in_if.target_y} - {in_if.robot_y[23], in_if.robot_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_if.valid;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ex_r   <= ex;
      f1_ey_r   <= ey;
      f1_zu_r   <= 32'd0 - {in_if.robot_yaw, 16'd0};
      f1_yerr_r <= in_if.target_yaw - in_if.robot_yaw;
      f1_use_r  <= in_if.use_yaw;
      f1_inr_r  <= (ex < 25'sd1048576) && (ex > -25'sd1048576) &&
                   (ey < 25'sd1048576) && (ey > -25'sd1048576);
    end
  end

  // second or third quadrant: turn the vector by half a turn
  assign neg   = f1_zu_r[31] ^ f1_zu_r[30];
  assign xs    = {{(CW-EW-8){f1_ex_r[EW-1]}}, f1_ex_r, 8'd0};
  assign ys    = {{(CW-EW-8){f1_ey_r[EW-1]}}, f1_ey_r, 8'd0};
  assign zf    = neg ? {~f1_zu_r[31], f1_zu_r[30:0]} : f1_zu_r;
  assign sqx   = f1_ex_r * f1_ex_r;
  assign sqy   = f1_ey_r * f1_ey_r;
  assign yprod = $signed(f1_yerr_r) * $signed({1'b0, cfg.kp_yaw}) + 34'sd128;

  always_ff @(posedge clk) begin
    if (en) begin
      f2_x_r     <= neg ? -xs : xs;
      f2_y_r     <= neg ? -ys : ys;
      f2_z_r     <= {{(ZW-32){zf[31]}}, zf};
      f2_sqx_r   <= sqx[39:0];
      f2_sqy_r   <= sqy[39:0];
      f2_tolsq_r <= cfg.pos_tol * cfg.pos_tol;
      f2_yprod_r <= yprod;
      f2_use_r   <= f1_use_r;
      f2_inr_r   <= f1_inr_r;
    end
  end

  assign sq_sum = {1'b0, f2_sqx_r} + {1'b0, f2_sqy_r};
  assign wzr    = f2_yprod_r[33:8];
  assign wabs   = wzr[WZW-1] ? WZW'(-wzr) : WZW'(wzr);

  always_comb begin
    job          = '0;
    job.x        = f2_x_r;
    job.y        = f2_y_r;
    job.z        = f2_z_r;
    job.pos_zero = f2_inr_r && (sq_sum < {1'b0, f2_tolsq_r});
    if (f2_use_r && (wabs >= {{(WZW-16){1'b0}}, cfg.yaw_tol})) begin
      job.wz = wzr;
    end
  end

endmodule

@@ rtl/core/wp_queue.sv @@
// short item queue between front and back
module wp_queue import wp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  wp_job_t   push_data,
  input  logic      pop,
  output wp_job_t   pop_data,
  output wp_qstat_t qstat
);

  wp_job_t        mem_r [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;

  assign qstat.full  = (cnt_r == (QAW+1)'(Q_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign pop_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/wp_back.sv @@
// back end: pipelined cordic rotation, gain scaling, deadband and saturation
module wp_back import wp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  wp_cfg_t   cfg,
  input  wp_job_t   job,
  input  wp_qstat_t qstat,
  output logic      pop,
  wp_out_if.source  out_if
);

  localparam logic signed [CW+16:0] HALF_P = (CW+17)'(32768);

  logic en;

  wp_job_t                  st_r [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] sv_r;

  logic                  k_v_r, p_v_r, o_v_r;
  logic signed [CW-1:0]  kx_r, ky_r;
  logic                  k_pz_r, p_pz_r;
  logic signed [WZW-1:0] k_wz_r, p_wz_r;
  logic signed [CW+16:0] px_r, py_r;
  logic signed [23:0]    ox_r, oy_r, ow_r;

  logic signed [CW+16:0] kx_prod, ky_prod, px_prod, py_prod;
  logic signed [36:0]    vx, vy, wz;

  function automatic logic signed [23:0] sat(input logic signed [36:0] v,
                                             input logic [22:0] lim);
    logic signed [36:0] l;
    l = $signed({14'd0, lim});
    if (v > l) begin
      return l[23:0];
    end else if (v < -l) begin
      return 24'(-l);
    end
    return v[23:0];
  endfunction

  assign en  = !o_v_r || out_if.ready;
  assign pop = en && !qstat.empty;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    wp_job_t cur, nxt;
    if (i == 0) begin : g_first
      assign cur = job;
    end else begin : g_rest
      assign cur = st_r[i-1];
    end
    always_comb begin
      nxt = cur;
      if (!cur.z[ZW-1]) begin
        nxt.x = cur.x - ($signed(cur.y) >>> i);
        nxt.y = cur.y + ($signed(cur.x) >>> i);
        nxt.z = cur.z - atan_ang(i);
      end else begin
        nxt.x = cur.x + ($signed(cur.y) >>> i);
        nxt.y = cur.y - ($signed(cur.x) >>> i);
        nxt.z = cur.z + atan_ang(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r  <= '0;
      k_v_r <= 1'b0;
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      sv_r  <= {sv_r[CORDIC_STAGES-2:0], !qstat.empty};
      k_v_r <= sv_r[CORDIC_STAGES-1];
      p_v_r <= k_v_r;
      o_v_r <= p_v_r;
    end
  end

  // cordic gain compensation, floor shift; position gain, rounded by adding half
  assign kx_prod = st_r[CORDIC_STAGES-1].x * $signed({1'b0, INV_K});
  assign ky_prod = st_r[CORDIC_STAGES-1].y * $signed({1'b0, INV_K});
  assign px_prod = kx_r * $signed({1'b0, cfg.kp_pos}) + HALF_P;
  assign py_prod = ky_r * $signed({1'b0, cfg.kp_pos}) + HALF_P;

  assign vx = p_pz_r ? '0 : px_r[CW+16:16];
  assign vy = p_pz_r ? '0 : py_r[CW+16:16];
  assign wz = 37'(p_wz_r);

  always_ff @(posedge clk) begin
    if (en) begin
      kx_r   <= kx_prod[CW+15:16];
      ky_r   <= ky_prod[CW+15:16];
      k_pz_r <= st_r[CORDIC_STAGES-1].pos_zero;
      k_wz_r <= st_r[CORDIC_STAGES-1].wz;
      px_r   <= px_prod;
      py_r   <= py_prod;
      p_pz_r <= k_pz_r;
      p_wz_r <= k_wz_r;
      ox_r   <= sat(vx, cfg.max_vx);
      oy_r   <= sat(vy, cfg.max_vy);
      ow_r   <= sat(wz, cfg.max_wz);
    end
  end

  assign out_if.valid    = o_v_r;
  assign out_if.vel_x    = ox_r;
  assign out_if.vel_y    = oy_r;
  assign out_if.yaw_rate = ow_r;

endmodule

@@ tb/tb.sv @@
// testbench for waypoint_velocity_command: queued pose items, self-checking velocity commands
`timescale 1ns / 1ps

module tb;
  import wp_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int PIPE_WAIT      = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 9;
  localparam int POSES_PER_SET  = 125;
  localparam int LONG_HOLD      = 90;
  localparam int HOLD_AT        = 300;
  localparam longint INV_GAIN   = 39797;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam longint ATAN_STEP [0:15] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D
  };

  typedef struct packed {
    logic [23:0] robot_x;
    logic [23:0] robot_y;
    logic [15:0] robot_yaw;
    logic [23:0] target_x;
    logic [23:0] target_y;
    logic [15:0] target_yaw;
    logic        use_yaw;
  } pose_item_t;

  typedef struct packed {
    logic [23:0] vel_x;
    logic [23:0] vel_y;
    logic [23:0] yaw_rate;
  } vel_cmd_t;

  logic clk;
  logic rst_n;

  wp_in_if  in_if();
  wp_out_if out_if();
  wp_cfg_if cfg_if();

  waypoint_velocity_command u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  pose_item_t pending_poses[$];
  vel_cmd_t   expected_cmds[$];
  wp_cfg_t    gains;
  pose_item_t on_wire;
  bit         calm;
  int         send_gap;
  int         stall_left;
  int         hold_left;
  bit         long_hold_done;
  int         poses_sent;
  int         results_seen;
  int         mismatches;
  int         in_stall_cycles;
  int         reg_writes;
  int         idle_cycles;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic longint sx24(logic [23:0] v);
    return {{40{v[23]}}, v};
  endfunction

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic vel_cmd_t body_velocity(pose_item_t p, wp_cfg_t c);
    longint ex, ey, x, y, z, dx, dy, vx, vy, wz, err, sq, tol, kp, ky;
    logic [31:0] ang;
    logic [15:0] dyaw;
    vel_cmd_t r;
    ex = sx24(p.target_x) - sx24(p.robot_x);
    ey = sx24(p.target_y) - sx24(p.robot_y);
    x = ex * 256;
    y = ey * 256;
    ang = 32'd0 - {p.robot_yaw, 16'd0};
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      x = -x;
      y = -y;
      ang = ang + 32'h8000_0000;
    end
    z = {{32{ang[31]}}, ang};
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP[i];
      end
    end
    x = (x * INV_GAIN) >>> 16;
    y = (y * INV_GAIN) >>> 16;
    kp = c.kp_pos;
    vx = (x * kp + 32768) >>> 16;
    vy = (y * kp + 32768) >>> 16;
    if (ex < 1048576 && ex > -1048576 && ey < 1048576 && ey > -1048576) begin
      sq = ex * ex + ey * ey;
      tol = c.pos_tol;
      if (sq < tol * tol) begin
        vx = 0;
        vy = 0;
      end
    end
    wz = 0;
    if (p.use_yaw) begin
      dyaw = p.target_yaw - p.robot_yaw;
      err = {{48{dyaw[15]}}, dyaw};
      ky = c.kp_yaw;
      wz = (err * ky + 128) >>> 8;
      tol = c.yaw_tol;
      if (wz < tol && wz > -tol) wz = 0;
    end
    vx = clamp_to(vx, longint'(c.max_vx));
    vy = clamp_to(vy, longint'(c.max_vy));
    wz = clamp_to(wz, longint'(c.max_wz));
    r.vel_x = vx[23:0];
    r.vel_y = vy[23:0];
    r.yaw_rate = wz[23:0];
    return r;
  endfunction

  function automatic pose_item_t pose(int rx, int ry, int ryaw, int tx, int ty, int tyaw,
                                      int uy);
    pose_item_t p;
    p.robot_x = rx[23:0];
    p.robot_y = ry[23:0];
    p.robot_yaw = ryaw[15:0];
    p.target_x = tx[23:0];
    p.target_y = ty[23:0];
    p.target_yaw = tyaw[15:0];
    p.use_yaw = uy[0];
    return p;
  endfunction

  function automatic int offset_near(int k);
    int d;
    d = $urandom & ((1 << k) - 1);
    if ($urandom_range(0, 1)) d = -d;
    return d;
  endfunction

  function automatic pose_item_t random_pose();
    int rx, ry, tx, ty, ryaw, tyaw, k, sel;
    rx = $urandom;
    ry = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      tx = $urandom;
      ty = $urandom;
    end else if (sel < 8) begin
      k = $urandom_range(0, 21);
      tx = rx + offset_near(k);
      ty = ry + offset_near(k);
    end else begin
      tx = rx + $urandom_range(0, 80) - 40;
      ty = ry + $urandom_range(0, 80) - 40;
    end
    if ($urandom_range(0, 4) == 0)
      ryaw = 16384 * $urandom_range(0, 3) + $urandom_range(0, 4) - 2;
    else
      ryaw = $urandom;
    sel = $urandom_range(0, 9);
    if (sel < 3) tyaw = ryaw + $urandom_range(0, 400) - 200;
    else if (sel == 3) tyaw = ryaw + 32768;
    else tyaw = $urandom;
    return pose(rx, ry, ryaw, tx, ty, tyaw, $urandom_range(0, 1));
  endfunction

  function automatic logic [22:0] pick_value(int ph, logic [22:0] top, logic [22:0] dflt);
    case (ph)
      1: return top;
      2: return '0;
      3: return dflt;
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return top;
          default: return 23'($urandom_range(0, int'(top)));
        endcase
      end
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [22:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_KP_POS:  gains.kp_pos = val[15:0];
      REG_KP_YAW:  gains.kp_yaw = val[15:0];
      REG_POS_TOL: gains.pos_tol = val[19:0];
      REG_YAW_TOL: gains.yaw_tol = val[15:0];
      REG_MAX_VX:  gains.max_vx = val;
      REG_MAX_VY:  gains.max_vy = val;
      REG_MAX_WZ:  gains.max_wz = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic program_gains(int ph);
    logic [22:0] top23;
    top23 = 23'h7FFFFF;
    write_reg(REG_KP_POS, {7'($urandom), 16'(pick_value(ph, 23'hFFFF, 23'd256))});
    write_reg(REG_KP_YAW, {7'($urandom), 16'(pick_value(ph, 23'hFFFF, 23'd512))});
    write_reg(REG_POS_TOL, {3'($urandom), 20'(pick_value(ph, 23'hFFFFF, 23'd20))});
    write_reg(REG_YAW_TOL, {7'($urandom), 16'(pick_value(ph, 23'hFFFF, 23'd182))});
    write_reg(REG_MAX_VX, pick_value(ph, top23, top23));
    write_reg(REG_MAX_VY, pick_value(ph, top23, top23));
    write_reg(REG_MAX_WZ, pick_value(ph, top23, top23));
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (pending_poses.size() != 0 || in_if.valid || expected_cmds.size() != 0);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic check_cmd(vel_cmd_t got);
    vel_cmd_t want;
    results_seen++;
    if (expected_cmds.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb: unexpected command vx=%h vy=%h wz=%h", got.vel_x, got.vel_y,
                 got.yaw_rate);
    end else begin
      want = expected_cmds.pop_front();
      if (got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
          got.yaw_rate !== want.yaw_rate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: command %0d expected vx=%h vy=%h wz=%h got vx=%h vy=%h wz=%h",
                   results_seen, want.vel_x, want.vel_y, want.yaw_rate,
                   got.vel_x, got.vel_y, got.yaw_rate);
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_cmds.push_back(body_velocity(on_wire, gains));
        poses_sent++;
      end
      if (in_if.valid && !in_if.ready) in_stall_cycles++;
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_poses.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 3);
          in_if.valid <= 1'b0;
        end else begin
          on_wire = pending_poses.pop_front();
          in_if.valid <= 1'b1;
          in_if.robot_x <= on_wire.robot_x;
          in_if.robot_y <= on_wire.robot_y;
          in_if.robot_yaw <= on_wire.robot_yaw;
          in_if.target_x <= on_wire.target_x;
          in_if.target_y <= on_wire.target_y;
          in_if.target_yaw <= on_wire.target_yaw;
          in_if.use_yaw <= on_wire.use_yaw;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready)
        check_cmd('{vel_x: out_if.vel_x, vel_y: out_if.vel_y, yaw_rate: out_if.yaw_rate});
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("tb: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.robot_x = '0;
    in_if.robot_y = '0;
    in_if.robot_yaw = '0;
    in_if.target_x = '0;
    in_if.target_y = '0;
    in_if.target_yaw = '0;
    in_if.use_yaw = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    gains = '{kp_pos: 16'd256, kp_yaw: 16'd512, pos_tol: 20'd20, yaw_tol: 16'd182,
              max_vx: 23'd1024, max_vy: 23'd1024, max_wz: 23'd16384};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset gains: extremes, quadrant edges, half turn, both deadband edges
    pending_poses.push_back(pose(0, 0, 0, 0, 0, 0, 0));
    pending_poses.push_back(pose(8388607, 8388607, 0, -8388608, -8388608, 65535, 1));
    pending_poses.push_back(pose(-8388608, -8388608, 65535, 8388607, 8388607, 0, 0));
    pending_poses.push_back(pose(0, 0, 16384, 1000, 0, 16384, 1));
    pending_poses.push_back(pose(100, -200, 32768, 1100, -700, 0, 1));
    pending_poses.push_back(pose(0, 0, 49152, 0, 1000, 0, 0));
    pending_poses.push_back(pose(0, 0, 16383, 900, 300, 16383, 1));
    pending_poses.push_back(pose(0, 0, 16385, 900, 300, 16385, 1));
    pending_poses.push_back(pose(0, 0, 0, 0, 0, 32768, 1));
    pending_poses.push_back(pose(5, 5, 32767, 5, 5, 65535, 1));
    pending_poses.push_back(pose(0, 0, 1000, 0, 0, 1090, 1));
    pending_poses.push_back(pose(0, 0, 1000, 0, 0, 1091, 1));
    pending_poses.push_back(pose(0, 0, 1000, 0, 0, 909, 1));
    pending_poses.push_back(pose(0, 0, 65535, 0, 0, 0, 1));
    pending_poses.push_back(pose(0, 0, 0, 19, 0, 0, 0));
    pending_poses.push_back(pose(0, 0, 0, 12, 16, 0, 0));
    pending_poses.push_back(pose(0, 0, 0, 11, 16, 0, 0));
    pending_poses.push_back(pose(-3000, 4000, 20000, -3000, 4000, 60000, 0));
    wait_drain();

    for (int ph = 1; ph <= PHASES; ph++) begin
      program_gains(ph);
      if (ph == 1) begin
        write_reg(REG_UNUSED, 23'($urandom));
        pending_poses.push_back(pose(0, 0, 0, 1048575, 0, 0, 1));
        pending_poses.push_back(pose(0, 0, 0, 1048574, 0, 0, 1));
        pending_poses.push_back(pose(0, 0, 0, 1048576, 0, 0, 1));
        pending_poses.push_back(pose(0, 0, 0, 0, -1048576, 0, 1));
      end
      if (ph == PHASES) calm = 1'b1;
      repeat (POSES_PER_SET) pending_poses.push_back(random_pose());
      wait_drain();
    end

    $display("tb: %0d poses sent, %0d commands checked, %0d gain sets, %0d register writes",
             poses_sent, results_seen, PHASES + 1, reg_writes);
    $display("tb: input held back %0d cycles, long output hold of %0d cycles, %0d mismatches",
             in_stall_cycles, LONG_HOLD, mismatches);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
